// File: design/frf_pkg.sv
// ----------------------------------------------------------------------------
// frf_pkg: shared types and constants of the false position root finder
// Result status codes, register indexes and reset values, operand and
// state encodings, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package frf_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STAT_CONVERGED   = 3'd0,
      STAT_NO_SIGN     = 3'd1,
      STAT_LOW_ROOT    = 3'd2,
      STAT_HIGH_ROOT   = 3'd3,
      STAT_CAP_REACHED = 3'd4
   } status_type;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 31;
   localparam int TOL_WIDTH       = 31;
   localparam int ITER_WIDTH      = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE      = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITERATIONS = 1'd1;

   localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET = 31'd1678;
   localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET  = 16'd1000;

   localparam int STATUS_WIDTH = 3;

   // multiplier operand choice
   typedef enum logic [1:0] {
      MUL_SQ_LOW,
      MUL_SQ_HIGH,
      MUL_SQ_MID,
      MUL_FP
   } mul_sel_type;

   // source of the new mid point
   typedef enum logic [1:0] {
      MID_LOW,
      MID_HIGH,
      MID_ZERO,
      MID_FP
   } mid_sel_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_LOW,
      S_WAIT_LOW,
      S_SQ_HIGH,
      S_WAIT_HIGH,
      S_CLASSIFY,
      S_FP_MUL,
      S_WAIT_FP_MUL,
      S_WAIT_DIV,
      S_CHECK_TOL,
      S_WAIT_MID,
      S_CHECK_MID,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        cap_fa;
      logic        cap_fb;
      logic        cap_fm;
      logic        div_start;
      logic        mid_load;
      mid_sel_type mid_sel;
      logic        step;
      logic        out_load;
      status_type  out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic fa_zero;
      logic fb_zero;
      logic same_sign;
      logic tol_ok;
      logic fm_zero;
      logic cap_hit;
   } sts_type;

endpackage

// File: design/frf_mul.sv
// ----------------------------------------------------------------------------
// frf_mul: shift and add multiplier
// Unsigned product of an AW-bit and a BW-bit operand, one multiplier bit
// per cycle from the top; done pulses once the product register is final.
// ----------------------------------------------------------------------------
module frf_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    mplr,
   input  logic [BW-1:0]    mcand,
   output logic             done,
   output logic [AW+BW-1:0] product
);

   localparam int CNTW = $clog2(AW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]    mplr_ff, mplr_in;
   logic [BW-1:0]    mcand_ff, mcand_in;
   logic [AW+BW-1:0] acc_ff, acc_in;

   // one add and shift per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mplr_in  = mplr;
         mcand_in = mcand;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in  = {acc_ff[AW+BW-2:0], 1'b0}
                 + (mplr_ff[AW-1] ? (AW+BW)'(mcand_ff) : '0);
         mplr_in = {mplr_ff[AW-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(AW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and product registers
   always_ff @(posedge clock) begin
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: design/frf_div.sv
// ----------------------------------------------------------------------------
// frf_div: restoring divider
// Divides {rem_init, dividend_low} by divisor, one quotient bit per cycle.
// The caller guarantees rem_init below divisor, so QW quotient bits suffice.
// ----------------------------------------------------------------------------
module frf_div #(
   parameter int QW = 32,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] rem_init,
   input  logic [QW-1:0] dividend_low,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CNTW = $clog2(QW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [QW-1:0]   low_ff, low_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [DW:0]     trial;
   logic            fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, low_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = rem_init;
         dvs_in  = divisor;
         low_in  = dividend_low;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         low_in = {low_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/frf_datapath.sv
// ----------------------------------------------------------------------------
// frf_datapath: interval registers, function evaluation and result register
// Holds the interval ends, the signs and magnitudes of f at both ends and at
// the mid point, the iteration count, the configuration registers and the
// result register; drives the shared multiplier and the divider.
// ----------------------------------------------------------------------------
module frf_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [frf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [frf_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic signed [DATA_WIDTH-1:0]         req_interval_low,
   input  logic signed [DATA_WIDTH-1:0]         req_interval_high,
   input  frf_pkg::cmd_type                     cmd,
   output frf_pkg::sts_type                     sts,
   output logic signed [DATA_WIDTH-1:0]         rsp_root,
   output logic [frf_pkg::ITER_WIDTH-1:0]       rsp_iterations,
   output logic [frf_pkg::STATUS_WIDTH-1:0]     rsp_status
);

   import frf_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   // shifted square, compare width, magnitude (saturated at 2^62-1)
   localparam int SQW = 2 * W - F;
   localparam int EW  = (SQW > F + 2) ? SQW : F + 2;
   localparam int MW  = (EW > 62) ? 62 : EW;
   localparam int XW  = EW + 63;
   // multiplicand, product, divisor and tolerance compare widths
   localparam int CW  = (W > MW) ? W : MW;
   localparam int PW  = W + CW;
   localparam int DW  = MW + 1;
   localparam int TW  = (W > TOL_WIDTH) ? W : TOL_WIDTH;

   logic signed [W-1:0] low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic                fa_neg_ff, fa_neg_in, fb_neg_ff, fb_neg_in, fm_neg_ff, fm_neg_in;
   logic [MW-1:0]       fa_mag_ff, fa_mag_in, fb_mag_ff, fb_mag_in, fm_mag_ff, fm_mag_in;
   logic [ITER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [TOL_WIDTH-1:0]  tol_ff, tol_in;
   logic [ITER_WIDTH-1:0] max_iter_ff, max_iter_in;
   logic signed [W-1:0]   root_ff, root_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic [STATUS_WIDTH-1:0] stat_ff, stat_in;

   logic [W-1:0]  low_abs, high_abs, mid_abs;
   logic [W:0]    low_x, mid_x, span, span_abs_x, sep, sep_abs_x;
   logic          span_neg;
   logic [W-1:0]  mul_mplr;
   logic [CW-1:0] mul_mcand;
   logic          mul_done;
   logic [PW-1:0] mul_product;
   logic [EW-1:0] sq_e, two_e, fdiff;
   logic [XW-1:0] fdiff_x;
   logic          f_neg;
   logic [MW-1:0] f_mag;
   logic [DW-1:0] div_rem_init, div_divisor;
   logic          div_done;
   logic [W-1:0]  quot;
   logic [W:0]    fp_x;
   logic [W-1:0]  fp_mid;

   // magnitudes and interval span
   assign low_abs    = low_ff[W-1]  ? W'(-low_ff)  : W'(low_ff);
   assign high_abs   = high_ff[W-1] ? W'(-high_ff) : W'(high_ff);
   assign mid_abs    = mid_ff[W-1]  ? W'(-mid_ff)  : W'(mid_ff);
   assign low_x      = {low_ff[W-1], low_ff};
   assign mid_x      = {mid_ff[W-1], mid_ff};
   assign span       = {high_ff[W-1], high_ff} - low_x;
   assign span_neg   = span[W];
   assign span_abs_x = span_neg ? (~span + 1'b1) : span;

   // multiplier operand selection
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQ_LOW: begin
            mul_mplr  = low_abs;
            mul_mcand = CW'(low_abs);
         end
         MUL_SQ_HIGH: begin
            mul_mplr  = high_abs;
            mul_mcand = CW'(high_abs);
         end
         MUL_SQ_MID: begin
            mul_mplr  = mid_abs;
            mul_mcand = CW'(mid_abs);
         end
         MUL_FP: begin
            mul_mplr  = span_abs_x[W-1:0];
            mul_mcand = CW'(fa_mag_ff);
         end
         default: begin
            mul_mplr  = low_abs;
            mul_mcand = CW'(low_abs);
         end
      endcase
   end

   frf_mul #(
      .AW (W),
      .BW (CW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mplr    (mul_mplr),
      .mcand   (mul_mcand),
      .done    (mul_done),
      .product (mul_product)
   );

   // f(x) = floor(x*x / 2^F) - 2, as sign and saturated magnitude
   assign sq_e    = EW'(mul_product[2*W-1:F]);
   assign two_e   = EW'(1) << (F + 1);
   assign f_neg   = sq_e < two_e;
   assign fdiff   = f_neg ? (two_e - sq_e) : (sq_e - two_e);
   assign fdiff_x = XW'(fdiff);
   assign f_mag   = (|fdiff_x[XW-1:62]) ? {MW{1'b1}} : fdiff_x[MW-1:0];

   // false position offset: |span| * |f(low)| / (|f(low)| + |f(high)|)
   assign div_rem_init = DW'(mul_product >> W);
   assign div_divisor  = DW'(fa_mag_ff) + DW'(fb_mag_ff);

   frf_div #(
      .QW (W),
      .DW (DW)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.div_start),
      .rem_init     (div_rem_init),
      .dividend_low (mul_product[W-1:0]),
      .divisor      (div_divisor),
      .done         (div_done),
      .quotient     (quot)
   );

   // new point, offset from the low end towards the high end
   assign fp_x   = span_neg ? (low_x - (W+1)'(quot)) : (low_x + (W+1)'(quot));
   assign fp_mid = fp_x[W-1:0];

   // distance of the mid point from the low end
   assign sep       = low_x - mid_x;
   assign sep_abs_x = sep[W] ? (~sep + 1'b1) : sep;

   // interval, function values and count
   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      mid_in    = mid_ff;
      fa_neg_in = fa_neg_ff;
      fa_mag_in = fa_mag_ff;
      fb_neg_in = fb_neg_ff;
      fb_mag_in = fb_mag_ff;
      fm_neg_in = fm_neg_ff;
      fm_mag_in = fm_mag_ff;
      cnt_in    = cnt_ff;
      if (cmd.load) begin
         low_in  = req_interval_low;
         high_in = req_interval_high;
         cnt_in  = '0;
      end
      if (cmd.cap_fa) begin
         fa_neg_in = f_neg;
         fa_mag_in = f_mag;
      end
      if (cmd.cap_fb) begin
         fb_neg_in = f_neg;
         fb_mag_in = f_mag;
      end
      if (cmd.cap_fm) begin
         fm_neg_in = f_neg;
         fm_mag_in = f_mag;
      end
      if (cmd.mid_load) begin
         case (cmd.mid_sel)
            MID_LOW:  mid_in = low_ff;
            MID_HIGH: mid_in = high_ff;
            MID_ZERO: mid_in = '0;
            MID_FP:   mid_in = fp_mid;
            default:  mid_in = '0;
         endcase
      end
      // replace the end whose sign matches f at the mid point
      if (cmd.step) begin
         if (fm_neg_ff != fa_neg_ff) begin
            high_in   = mid_ff;
            fb_neg_in = fm_neg_ff;
            fb_mag_in = fm_mag_ff;
         end else begin
            low_in    = mid_ff;
            fa_neg_in = fm_neg_ff;
            fa_mag_in = fm_mag_ff;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // configuration writes
   always_comb begin
      tol_in      = tol_ff;
      max_iter_in = max_iter_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TOLERANCE:      tol_in      = csr_data[TOL_WIDTH-1:0];
            CSR_MAX_ITERATIONS: max_iter_in = csr_data[ITER_WIDTH-1:0];
            default: begin
               tol_in      = tol_ff;
               max_iter_in = max_iter_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      root_in = root_ff;
      iter_in = iter_ff;
      stat_in = stat_ff;
      if (cmd.out_load) begin
         root_in = mid_ff;
         iter_in = cnt_ff;
         stat_in = cmd.out_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff      <= TOLERANCE_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         tol_ff      <= tol_in;
         max_iter_ff <= max_iter_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      fa_neg_ff <= fa_neg_in;
      fa_mag_ff <= fa_mag_in;
      fb_neg_ff <= fb_neg_in;
      fb_mag_ff <= fb_mag_in;
      fm_neg_ff <= fm_neg_in;
      fm_mag_ff <= fm_mag_in;
      cnt_ff    <= cnt_in;
      root_ff   <= root_in;
      iter_ff   <= iter_in;
      stat_ff   <= stat_in;
   end

   // status towards the controller
   assign sts.mul_done  = mul_done;
   assign sts.div_done  = div_done;
   assign sts.fa_zero   = (fa_mag_ff == '0);
   assign sts.fb_zero   = (fb_mag_ff == '0);
   assign sts.same_sign = (fa_neg_ff == fb_neg_ff);
   assign sts.tol_ok    = TW'(sep_abs_x[W-1:0]) <= TW'(tol_ff);
   assign sts.fm_zero   = (fm_mag_ff == '0);
   assign sts.cap_hit   = (cnt_ff >= max_iter_ff);

   assign rsp_root       = root_ff;
   assign rsp_iterations = iter_ff;
   assign rsp_status     = stat_ff;

endmodule

// File: design/frf_ctrl.sv
// ----------------------------------------------------------------------------
// frf_ctrl: sequencing controller
// Steps one interval through end evaluation, classification and the false
// position loop, and owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
module frf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  frf_pkg::sts_type sts,
   output frf_pkg::cmd_type cmd
);

   import frf_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.mul_sel    = MUL_SQ_LOW;
      cmd.mid_sel    = MID_LOW;
      cmd.out_status = status_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQ_LOW;
            end
         end
         S_SQ_LOW: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_SQ_LOW;
            state_in      = S_WAIT_LOW;
         end
         S_WAIT_LOW: begin
            if (sts.mul_done) begin
               cmd.cap_fa = 1'b1;
               state_in   = S_SQ_HIGH;
            end
         end
         S_SQ_HIGH: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_SQ_HIGH;
            state_in      = S_WAIT_HIGH;
         end
         S_WAIT_HIGH: begin
            if (sts.mul_done) begin
               cmd.cap_fb = 1'b1;
               state_in   = S_CLASSIFY;
            end
         end
         // end roots and missing sign change finish at once
         S_CLASSIFY: begin
            if (sts.fa_zero) begin
               cmd.mid_load = 1'b1;
               cmd.mid_sel  = MID_LOW;
               status_in    = STAT_LOW_ROOT;
               state_in     = S_FINISH;
            end else if (sts.fb_zero) begin
               cmd.mid_load = 1'b1;
               cmd.mid_sel  = MID_HIGH;
               status_in    = STAT_HIGH_ROOT;
               state_in     = S_FINISH;
            end else if (sts.same_sign) begin
               cmd.mid_load = 1'b1;
               cmd.mid_sel  = MID_ZERO;
               status_in    = STAT_NO_SIGN;
               state_in     = S_FINISH;
            end else begin
               state_in = S_FP_MUL;
            end
         end
         S_FP_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_FP;
            state_in      = S_WAIT_FP_MUL;
         end
         S_WAIT_FP_MUL: begin
            if (sts.mul_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_WAIT_DIV;
            end
         end
         S_WAIT_DIV: begin
            if (sts.div_done) begin
               cmd.mid_load = 1'b1;
               cmd.mid_sel  = MID_FP;
               state_in     = S_CHECK_TOL;
            end
         end
         S_CHECK_TOL: begin
            if (sts.tol_ok) begin
               status_in = STAT_CONVERGED;
               state_in  = S_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MUL_SQ_MID;
               state_in      = S_WAIT_MID;
            end
         end
         S_WAIT_MID: begin
            if (sts.mul_done) begin
               cmd.cap_fm = 1'b1;
               state_in   = S_CHECK_MID;
            end
         end
         // exact root, cap, or another refinement
         S_CHECK_MID: begin
            if (sts.fm_zero) begin
               status_in = STAT_CONVERGED;
               state_in  = S_FINISH;
            end else if (sts.cap_hit) begin
               status_in = STAT_CAP_REACHED;
               state_in  = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = S_FP_MUL;
            end
         end
         // wait for the result register to be free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/false_position_root_finder.sv
// ----------------------------------------------------------------------------
// false_position_root_finder: root of f(x) = x*x - 2 by false position
// Takes an interval [low, high] in signed fixed point and returns the
// refined root, the number of refinements and a status code.
//
// Input transfer: req_valid high and req_stall low; req_interval_low and
// req_interval_high are the two ends. One interval is worked at a time;
// req_stall is low only while the block is idle.
// Result transfer: rsp_valid high and rsp_stall low; rsp_root,
// rsp_iterations and rsp_status stay in an output register until taken,
// and the next interval is accepted while a result waits there.
// The multiplier and divider give one bit a cycle. The next interval is
// taken the cycle after the result is loaded.
// Configuration: csr_write with csr_index and csr_data writes tolerance or
// max_iterations. The user must write only while idle; it is not enforced.
// Reset (synchronous) returns the block to idle with no result pending
// and restores tolerance 1678 and max_iterations 1000.
// ----------------------------------------------------------------------------
module false_position_root_finder #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [frf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [frf_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [DATA_WIDTH-1:0]         req_interval_low,
   input  logic signed [DATA_WIDTH-1:0]         req_interval_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [DATA_WIDTH-1:0]         rsp_root,
   output logic [frf_pkg::ITER_WIDTH-1:0]       rsp_iterations,
   output logic [frf_pkg::STATUS_WIDTH-1:0]     rsp_status
);

   import frf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   frf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and storage
   frf_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_root          (rsp_root),
      .rsp_iterations    (rsp_iterations),
      .rsp_status        (rsp_status)
   );

`ifndef ASSERT_OFF
   // an accepted interval makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took no notice of an accepted interval");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while a result waits");

   // a loaded result is presented next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

   // refinement only when neither exact root nor cap ends the run
   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!sts.fm_zero && !sts.cap_hit))
      else $error("refinement past an exact root or the cap");
`endif

endmodule

// File: bench/frf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frf_checker: result checker for the false position root finder
// Watches the configuration port and both channels. Every accepted interval
// is solved here by its own fixed-point false position loop, and the answer
// is queued; every result transfer is compared field by field with the
// oldest queued answer. Mismatch and result counts go back to the bench top.
// ----------------------------------------------------------------------------
module frf_checker #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [frf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [frf_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_interval_low,
   input  logic signed [DATA_WIDTH-1:0]        req_interval_high,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [DATA_WIDTH-1:0]        rsp_root,
   input  logic [frf_pkg::ITER_WIDTH-1:0]      rsp_iterations,
   input  logic [frf_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  results_seen,
   output int                                  converged_seen,
   output int                                  capped_seen
);
   import frf_pkg::*;

   // value of f as a sign and a magnitude
   typedef struct {
      int          sgn;
      logic [63:0] mag;
   } fsample_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] root;
      logic [ITER_WIDTH-1:0]        iterations;
      status_type                   status;
   } answer_type;

   localparam logic [63:0] MAG_LIMIT = (64'd1 << 62) - 64'd1;

   answer_type           answers_due[$];
   answer_type           want;
   logic [TOL_WIDTH-1:0]  tol_now;
   logic [ITER_WIDTH-1:0] cap_now;
   int                   bad_fields;
   int                   results;
   int                   converged;
   int                   capped;

   // f(x) = floor(x*x / 2^FRAC_BITS) - 2.0, magnitude saturated
   function automatic fsample_type square_minus_two(input logic signed [63:0] x);
      fsample_type  r;
      logic [63:0]  ux;
      logic [127:0] sq;
      logic [127:0] two;
      ux  = x[63] ? 64'd0 - x : x;
      sq  = ({64'd0, ux} * {64'd0, ux}) >> FRAC_BITS;
      two = 128'd2 << FRAC_BITS;
      if (sq > two) begin
         r.sgn = 1;
         r.mag = (sq - two > {64'd0, MAG_LIMIT}) ? MAG_LIMIT : 64'(sq - two);
      end else if (sq == two) begin
         r.sgn = 0;
         r.mag = 64'd0;
      end else begin
         r.sgn = -1;
         r.mag = 64'(two - sq);
      end
      return r;
   endfunction

   // false position point, offset from a truncated toward a
   function automatic logic signed [63:0] chord_point(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input fsample_type fa,
                                                      input fsample_type fb);
      logic signed [63:0] span;
      logic [63:0]        uspan;
      logic [127:0]       offset;
      span   = b - a;
      uspan  = span[63] ? 64'd0 - span : span;
      offset = ({64'd0, uspan} * {64'd0, fa.mag}) / {64'd0, fa.mag + fb.mag};
      return span[63] ? a - offset[63:0] : a + offset[63:0];
   endfunction

   // full answer for one interval under the current settings
   function automatic answer_type solve_interval(input logic signed [DATA_WIDTH-1:0] lo,
                                                 input logic signed [DATA_WIDTH-1:0] hi);
      answer_type         ans;
      fsample_type        fa;
      fsample_type        fb;
      fsample_type        fm;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] m;
      logic signed [63:0] gap;
      logic [63:0]        sep;
      int unsigned        steps;
      logic               done;
      a     = lo;
      b     = hi;
      m     = 64'sd0;
      steps = 0;
      fa    = square_minus_two(a);
      fb    = square_minus_two(b);
      if (fa.sgn == 0) begin
         m          = a;
         ans.status = STAT_LOW_ROOT;
      end else if (fb.sgn == 0) begin
         m          = b;
         ans.status = STAT_HIGH_ROOT;
      end else if (fa.sgn == fb.sgn) begin
         m          = 64'sd0;
         ans.status = STAT_NO_SIGN;
      end else begin
         m    = chord_point(a, b, fa, fb);
         done = 1'b0;
         while (!done) begin
            gap = a - m;
            sep = gap[63] ? 64'd0 - gap : gap;
            if (sep <= tol_now) begin
               ans.status = STAT_CONVERGED;
               done       = 1'b1;
            end else begin
               fm = square_minus_two(m);
               if (fm.sgn == 0) begin
                  ans.status = STAT_CONVERGED;
                  done       = 1'b1;
               end else if (steps >= cap_now) begin
                  ans.status = STAT_CAP_REACHED;
                  done       = 1'b1;
               end else begin
                  // replace the end whose f has the sign of f(m)
                  if (fm.sgn != fa.sgn) begin
                     b  = m;
                     fb = fm;
                  end else begin
                     a  = m;
                     fa = fm;
                  end
                  m     = chord_point(a, b, fa, fb);
                  steps = steps + 1;
               end
            end
         end
      end
      ans.root       = m[DATA_WIDTH-1:0];
      ans.iterations = steps[ITER_WIDTH-1:0];
      return ans;
   endfunction

   // register writes, result compare, then queue the newly accepted interval
   always @(posedge clock) begin
      if (reset) begin
         tol_now    = TOLERANCE_RESET;
         cap_now    = MAX_ITER_RESET;
         bad_fields = 0;
         results    = 0;
         converged  = 0;
         capped     = 0;
         answers_due.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_TOLERANCE)
               tol_now = csr_data[TOL_WIDTH-1:0];
            else if (csr_index == CSR_MAX_ITERATIONS)
               cap_now = csr_data[ITER_WIDTH-1:0];
         end

         // result transfer
         if (rsp_valid && !rsp_stall) begin
            results = results + 1;
            if (answers_due.size() == 0) begin
               $display("%0t unexpected result: expected none, actual root %0d status %0d",
                        $time, rsp_root, rsp_status);
               bad_fields = bad_fields + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.status == STAT_CONVERGED)
                  converged = converged + 1;
               else if (want.status == STAT_CAP_REACHED)
                  capped = capped + 1;
               if (rsp_root !== want.root) begin
                  $display("%0t rsp_root: expected %0d, actual %0d",
                           $time, want.root, rsp_root);
                  bad_fields = bad_fields + 1;
               end
               if (rsp_iterations !== want.iterations) begin
                  $display("%0t rsp_iterations: expected %0d, actual %0d",
                           $time, want.iterations, rsp_iterations);
                  bad_fields = bad_fields + 1;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t rsp_status: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  bad_fields = bad_fields + 1;
               end
            end
         end

         // interval transfer
         if (req_valid && !req_stall)
            answers_due.push_back(solve_interval(req_interval_low, req_interval_high));
      end
      mismatches     <= bad_fields;
      outstanding    <= answers_due.size();
      results_seen   <= results;
      converged_seen <= converged;
      capped_seen    <= capped;
   end

endmodule

// File: bench/tb_false_position_root_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_false_position_root_finder: bench for the false position root finder
// Drives intervals and register settings into the block, stalls the result
// side at random and leaves all checking to frf_checker. Directed intervals
// cover the field extremes, ends on the roots and no sign change; random
// phases then mix converging brackets, wide brackets, noise and same-sign
// pairs under tolerances from zero and caps from one up to the maximum.
// ----------------------------------------------------------------------------
module tb_false_position_root_finder;
   import frf_pkg::*;

   localparam int DW = 32;
   localparam int FB = 24;
   localparam int PERIOD = 10;

   // cycles of one refinement and of the set-up before the first one
   localparam int CYCLES_PER_STEP = 3 * DW + 6;
   localparam int SETUP_CYCLES    = 2 * DW + 6;

   localparam logic signed [DW-1:0] UNIT       = 32'sd16777216;
   localparam logic signed [DW-1:0] NEAR_BELOW = 32'sd23726566;
   localparam logic signed [DW-1:0] NEAR_ABOVE = 32'sd23726567;
   localparam logic signed [DW-1:0] MOST_NEG   = 32'sh8000_0000;
   localparam logic signed [DW-1:0] MOST_POS   = 32'sh7fff_ffff;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_data;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [DW-1:0]         req_interval_low;
   logic signed [DW-1:0]         req_interval_high;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [DW-1:0]         rsp_root;
   logic [ITER_WIDTH-1:0]        rsp_iterations;
   logic [STATUS_WIDTH-1:0]      rsp_status;

   int   mismatches;
   int   outstanding;
   int   results_seen;
   int   converged_seen;
   int   capped_seen;
   int   idle_cycles;
   int   idle_limit;
   int   stall_left;
   int   stall_draw;
   logic steady;

   always #(PERIOD / 2) clock = ~clock;

   false_position_root_finder #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FB)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_root          (rsp_root),
      .rsp_iterations    (rsp_iterations),
      .rsp_status        (rsp_status)
   );

   frf_checker #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FB)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_root          (rsp_root),
      .rsp_iterations    (rsp_iterations),
      .rsp_status        (rsp_status),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .results_seen      (results_seen),
      .converged_seen    (converged_seen),
      .capped_seen       (capped_seen)
   );

   // idle cycles before an interval or before taking a result
   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(12);
   endfunction

   // longest quiet spell a correct block can show under a given cap
   function automatic int limit_for(input int cap);
      return 4 * ((cap + 1) * CYCLES_PER_STEP + SETUP_CYCLES + 24) + 1000;
   endfunction

   // random end either inside the two roots or beyond them, random sign
   function automatic logic signed [DW-1:0] pick_end(input logic beyond, input logic wide);
      logic signed [DW-1:0] mag;
      if (!beyond)
         mag = $urandom_range(NEAR_BELOW);
      else if (!wide)
         mag = $urandom_range(UNIT * 4, NEAR_ABOVE);
      else if ($urandom_range(15) == 0)
         return MOST_NEG;
      else
         mag = $urandom_range(MOST_POS, NEAR_ABOVE);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // bracket whose low end walks to the root, so it settles in few steps
   function automatic void pick_converging(output logic signed [DW-1:0] lo,
                                           output logic signed [DW-1:0] hi);
      lo = $urandom_range(NEAR_BELOW);
      hi = $urandom_range(UNIT * 4, NEAR_ABOVE);
      if ($urandom_range(1)) begin
         lo = -lo;
         hi = -hi;
      end
   endfunction

   // one interval transfer after a drawn gap
   task automatic send_interval(input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_interval_low  <= lo;
      req_interval_high <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender until every queued answer has been matched
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // both registers, written only with the block idle
   task automatic write_config(input logic [TOL_WIDTH-1:0] tol,
                               input logic [ITER_WIDTH-1:0] cap);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_TOLERANCE;
      csr_data  <= tol;
      @(posedge clock);
      csr_index <= CSR_MAX_ITERATIONS;
      csr_data  <= CSR_DATA_WIDTH'(cap);
      @(posedge clock);
      csr_write  <= 1'b0;
      idle_limit <= limit_for(int'(cap));
      @(posedge clock);
   endtask

   // result side: hold off each result for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = draw_gap();
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= idle_limit) begin
         $display("[false_position_root_finder] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [DW-1:0] lo;
      logic signed [DW-1:0] hi;
      logic signed [DW-1:0] held;
      int                   pick;
      logic                 beyond;

      reset             = 1'b1;
      csr_write         = 1'b0;
      csr_index         = CSR_TOLERANCE;
      csr_data          = '0;
      req_valid         = 1'b0;
      req_interval_low  = '0;
      req_interval_high = '0;
      idle_limit        = limit_for(int'(MAX_ITER_RESET));
      steady            = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: classic brackets, ends at the roots, no sign change
      send_interval(UNIT, UNIT * 2);
      send_interval(-UNIT, -UNIT * 2);
      send_interval(32'sd0, 32'sd0);
      send_interval(UNIT * 3, UNIT * 5);
      send_interval(NEAR_BELOW, NEAR_ABOVE);
      send_interval(NEAR_ABOVE, NEAR_BELOW);
      send_interval(-NEAR_BELOW, -NEAR_ABOVE);
      send_interval(-NEAR_ABOVE, NEAR_ABOVE);
      send_interval(MOST_NEG, MOST_POS);
      send_interval(MOST_POS, MOST_NEG);
      send_interval(MOST_NEG, MOST_NEG);

      // zero tolerance, cap of one: the cap stops nearly everything
      steady <= 1'b1;
      write_config('0, 16'd1);
      send_interval(-UNIT * 2, -UNIT);
      send_interval(32'sd0, MOST_POS);
      send_interval(MOST_NEG, 32'sd0);
      send_interval(MOST_POS, 32'sd0);
      send_interval(32'sd0, MOST_NEG);
      send_interval(UNIT, NEAR_ABOVE);

      // zero tolerance, full cap: only brackets that settle quickly
      steady <= 1'b0;
      write_config('0, 16'hffff);
      send_interval(UNIT, UNIT * 2);
      send_interval(-UNIT, -UNIT * 2);
      send_interval(32'sd0, UNIT * 2);
      send_interval(NEAR_BELOW, UNIT * 4);
      for (int k = 0; k < 6; k++) begin
         pick_converging(lo, hi);
         send_interval(lo, hi);
      end

      // widest tolerance: ends kept within 2^31 of each other so no refinement runs
      steady <= ($urandom_range(1) == 0);
      write_config({TOL_WIDTH{1'b1}}, 16'hffff);
      for (int k = 0; k < 15; k++) begin
         lo = $urandom_range(MOST_POS) - (UNIT * 64);
         hi = $urandom_range(MOST_POS) - (UNIT * 64);
         send_interval(lo, hi);
      end

      // random phases, small caps, mostly well-formed brackets
      for (int p = 0; p < 5; p++) begin
         steady <= ($urandom_range(3) == 0);
         write_config(TOL_WIDTH'($urandom_range(1 << 20)),
                      ITER_WIDTH'($urandom_range(24, 1)));
         for (int k = 0; k < 20; k++) begin
            pick = $urandom_range(19);
            if (pick < 7) begin
               pick_converging(lo, hi);
            end else begin
               if (pick < 12) begin
                  lo = pick_end(1'b0, 1'b1);
                  hi = pick_end(1'b1, 1'b1);
               end else if (pick < 15) begin
                  lo = $urandom();
                  hi = $urandom();
               end else if (pick < 17) begin
                  beyond = 1'($urandom_range(1));
                  lo     = pick_end(beyond, 1'b1);
                  hi     = pick_end(beyond, 1'b1);
               end else begin
                  lo = NEAR_BELOW - 1 + $urandom_range(3);
                  if ($urandom_range(1))
                     lo = -lo;
                  hi = pick_end(1'($urandom_range(1)), 1'b0);
               end
               if ($urandom_range(1)) begin
                  held = lo;
                  lo   = hi;
                  hi   = held;
               end
            end
            if ($urandom_range(24) == 0)
               drain();
            send_interval(lo, hi);
         end
      end

      // let the last results through, then a quiet spell for strays
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETUP_CYCLES + CYCLES_PER_STEP) @(posedge clock);

      $display("%0d results checked: %0d converged, %0d stopped by the cap, %0d other",
               results_seen, converged_seen, capped_seen,
               results_seen - converged_seen - capped_seen);
      $display("tolerance swept from zero to full scale, iteration cap from 1 to 65535");
      if (mismatches == 0 && outstanding == 0)
         $display("[false_position_root_finder] OK");
      else
         $display("[false_position_root_finder] ERROR");
      $finish;
   end

endmodule

// File: files.f
design/frf_pkg.sv
design/frf_mul.sv
design/frf_div.sv
design/frf_datapath.sv
design/frf_ctrl.sv
design/false_position_root_finder.sv
bench/frf_checker.sv
bench/tb_false_position_root_finder.sv
